// ===== rtl/core/world_point_screen_projection_top_macros.svh =====
// Assertion macros used by the projection block's checker.
`ifndef WORLD_POINT_SCREEN_PROJECTION_TOP_MACROS_SVH
`define WORLD_POINT_SCREEN_PROJECTION_TOP_MACROS_SVH

// Assertion that is switched off while reset is applied.
`define WPSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion that also holds across reset.
`define WPSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/wpsp_pkg.sv =====
// Types, constants and helpers of the world point screen projection block.
package wpsp_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned ScreenW     = 14;
  localparam int unsigned SumW        = 66;

  localparam logic [ScreenW-1:0] WidthReset  = 14'd1920;
  localparam logic [ScreenW-1:0] HeightReset = 14'd1080;

  // Item operation codes.
  typedef enum logic {
    OpLoad      = 1'b0,
    OpTransform = 1'b1
  } op_e;

  // Configuration register indexes.
  typedef enum logic {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_e;

  typedef struct packed {
    logic                     op;
    logic [1:0]               row_index;
    logic signed [CoordW-1:0] coef_a;
    logic signed [CoordW-1:0] coef_b;
    logic signed [CoordW-1:0] coef_c;
    logic signed [CoordW-1:0] coef_d;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
    logic                     inside_view;
    logic                     w_was_zero;
  } out_item_t;

  // Saturate a wide signed value to the 32-bit coordinate range.
  function automatic logic signed [CoordW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(signed'(32'sh7fffffff));
    lo = SumW'(signed'(32'sh80000000));
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[CoordW-1:0];
  endfunction

endpackage

// ===== rtl/core/world_point_screen_projection_top.sv =====
// Top level of the world point screen projection pipeline.

// Projects world points to screen pixels through a loaded 4x4 matrix, a
// division by w and the viewport mapping. One item is taken every cycle while
// the output is not held back; a load item writes a matrix row and yields no
// result. A transform result passes through the input register, the products,
// the row sums, the divider operand preparation, one divider entry per quotient
// bit of the restoring divider (32 + FRAC_BITS bits), sign, the viewport product
// and the output register. A held output freezes the whole pipeline.
module world_point_screen_projection_top #(
  parameter int unsigned FRAC_BITS = wpsp_pkg::FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  wpsp_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output wpsp_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import wpsp_pkg::*;

  localparam int unsigned QW = CoordW + FRAC_BITS;
  localparam logic signed [CoordW:0] One = (CoordW+1)'(1) << FRAC_BITS;
  localparam logic [CoordW-1:0] Max32 = 32'h7fffffff;

  // Pipeline advance: everything moves unless a finished result is held.
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Configuration registers.
  logic [ScreenW-1:0] width_q, height_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegWidth) begin
        width_q <= pwdata[ScreenW-1:0];
      end else begin
        height_q <= pwdata[ScreenW-1:0];
      end
    end
  end
  assign prdata = (paddr[2] == RegWidth) ? {18'd0, width_q} : {18'd0, height_q};

  // Matrix rows are written when a load item is transferred.
  logic signed [CoordW-1:0] mat_q [4][4];
  logic in_acc;
  assign in_acc = in_valid_i && adv;
  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.op == OpLoad) begin
      mat_q[in_data_i.row_index][0] <= in_data_i.coef_a;
      mat_q[in_data_i.row_index][1] <= in_data_i.coef_b;
      mat_q[in_data_i.row_index][2] <= in_data_i.coef_c;
      mat_q[in_data_i.row_index][3] <= in_data_i.coef_d;
    end
  end

  // Stage 0: input register for transform items.
  logic s0_vld_q;
  logic signed [CoordW-1:0] p_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_valid_i && in_data_i.op == OpTransform;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= in_data_i.point_x;
      p_q[1] <= in_data_i.point_y;
      p_q[2] <= in_data_i.point_z;
    end
  end

  // Stage 1: products, floored by the fraction width. The constant column
  // times one floors back to the coefficient itself.
  logic s1_vld_q;
  logic signed [63:0] pr_q [4][4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s0_vld_q;
    end
  end
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [63:0] prod;
      assign prod = 64'(mat_q[r][c]) * 64'(p_q[c]);
      always_ff @(posedge clk_i) begin
        if (adv) begin
          pr_q[r][c] <= prod >>> FRAC_BITS;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pr_q[r][3] <= 64'(mat_q[r][3]);
      end
    end
  end

  // Stage 2: exact row sums, saturated to 32 bits.
  logic s2_vld_q;
  logic signed [CoordW-1:0] hv_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end
  for (genvar r = 0; r < 4; r++) begin : g_sum
    logic signed [SumW-1:0] sum;
    assign sum = SumW'(pr_q[r][0]) + SumW'(pr_q[r][1]) + SumW'(pr_q[r][2])
               + SumW'(pr_q[r][3]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        hv_q[r] <= sat32(sum);
      end
    end
  end

  // Divider pipeline: entry 0 holds the prepared operands, each later entry
  // one more quotient bit of a restoring division on magnitudes.
  logic                     dv_vld_q [QW+1];
  logic [CoordW-1:0]        dd_q     [QW+1];
  logic                     wz_q     [QW+1];
  logic signed [CoordW-1:0] raw_q    [3][QW+1];
  logic                     neg_q    [3][QW+1];
  logic [QW-1:0]            nq_q     [3][QW+1];
  logic [CoordW-1:0]        rem_q    [3][QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_q[0] <= s2_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q[0] <= hv_q[3][CoordW-1] ? CoordW'(-hv_q[3]) : hv_q[3];
      wz_q[0] <= (hv_q[3] == '0);
    end
  end
  for (genvar l = 0; l < 3; l++) begin : g_prep
    logic [CoordW-1:0] mag;
    assign mag = hv_q[l][CoordW-1] ? CoordW'(-hv_q[l]) : hv_q[l];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        raw_q[l][0] <= hv_q[l];
        neg_q[l][0] <= hv_q[l][CoordW-1] ^ hv_q[3][CoordW-1];
        nq_q[l][0]  <= {mag, {FRAC_BITS{1'b0}}};
        rem_q[l][0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dd_q[k+1] <= dd_q[k];
        wz_q[k+1] <= wz_q[k];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [CoordW:0] r2;
      logic [CoordW:0] diff;
      logic            ge;
      assign r2   = {rem_q[l][k], nq_q[l][k][QW-1]};
      assign diff = r2 - {1'b0, dd_q[k]};
      assign ge   = (r2 >= {1'b0, dd_q[k]});
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[l][k+1] <= ge ? diff[CoordW-1:0] : r2[CoordW-1:0];
          nq_q[l][k+1]  <= {nq_q[l][k][QW-2:0], ge};
          raw_q[l][k+1] <= raw_q[l][k];
          neg_q[l][k+1] <= neg_q[l][k];
        end
      end
    end
  end

  // Stage P: sign, saturation, and the undivided bypass for zero w. The
  // divided w is exactly one, and the undivided w of the bypass is zero.
  logic pv_vld_q, pv_wz_q;
  logic signed [CoordW-1:0] pf_q [3];
  logic signed [CoordW-1:0] pw_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_vld_q <= 1'b0;
    end else if (adv) begin
      pv_vld_q <= dv_vld_q[QW];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pv_wz_q <= wz_q[QW];
      pw_q    <= wz_q[QW] ? '0 : CoordW'(One);
    end
  end
  for (genvar l = 0; l < 3; l++) begin : g_fin
    logic [QW-1:0]            q;
    logic signed [CoordW-1:0] res;
    assign q = nq_q[l][QW];
    always_comb begin
      if (!neg_q[l][QW]) begin
        res = (q > QW'(Max32)) ? 32'sh7fffffff : q[CoordW-1:0];
      end else begin
        res = (q > QW'(Max32) + QW'(1)) ? 32'sh80000000 : CoordW'(-q[CoordW-1:0]);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pf_q[l] <= wz_q[QW] ? raw_q[l][QW] : res;
      end
    end
  end

  // Stage M: viewport products and the clip test.
  logic mv_vld_q, mv_wz_q, mv_in_q;
  logic signed [47:0] sxp_q, syp_q;
  logic signed [CoordW:0] xa, ya;
  logic signed [CoordW-1:0] wf;
  logic clip_in;
  assign wf = pw_q;
  assign xa = 33'(pf_q[0]) + One;
  assign ya = One - 33'(pf_q[1]);
  assign clip_in = (pf_q[0] >= -33'(wf)) && (pf_q[0] <= wf)
                && (pf_q[1] >= -33'(wf)) && (pf_q[1] <= wf)
                && (pf_q[2] >= 0) && (pf_q[2] <= wf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_vld_q <= 1'b0;
    end else if (adv) begin
      mv_vld_q <= pv_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sxp_q   <= 48'(xa) * 48'(signed'({1'b0, width_q}));
      syp_q   <= 48'(ya) * 48'(signed'({1'b0, height_q}));
      mv_in_q <= clip_in;
      mv_wz_q <= pv_wz_q;
    end
  end

  // Output register: halve with floor and saturate.
  logic ov_q;
  out_item_t od_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= mv_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      od_q.screen_x    <= sat32(SumW'(sxp_q >>> 1));
      od_q.screen_y    <= sat32(SumW'(syp_q >>> 1));
      od_q.inside_view <= mv_in_q;
      od_q.w_was_zero  <= mv_wz_q;
    end
  end
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

// ===== rtl/core/wpsp_checker.sv =====
// Port-level checker for the projection block, bound to the top level.
`include "world_point_screen_projection_top_macros.svh"

module wpsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input wpsp_pkg::out_item_t out_data_o
);
  import wpsp_pkg::*;

  // The input is held back exactly when a finished result is held back.
  `WPSP_ASSERT(a_stall_link, in_stall_o == (out_valid_o && out_stall_i), "stall mismatch")

  // A held result keeps its payload.
  `WPSP_ASSERT(a_hold, out_valid_o && out_stall_i |=> $stable(out_data_o), "payload changed")

  // Nothing comes out right after reset.
  `WPSP_ASSERT_ALWAYS(a_reset_empty, !$past(rst_ni) |-> !out_valid_o, "result after reset")

endmodule

bind world_point_screen_projection_top wpsp_checker u_wpsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the world point screen projection block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wpsp_pkg::*;

  localparam int unsigned Frac      = 16;
  localparam int unsigned DrainWait = 120;
  localparam int unsigned Watchdog  = 20000;
  localparam int unsigned InW       = $bits(in_item_t);
  localparam logic signed [31:0] One = 32'sh0001_0000;
  localparam logic signed [31:0] SMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMin = 32'sh8000_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  world_point_screen_projection_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the matrix and the viewport size.
  logic signed [31:0] view_mat [16];
  logic [13:0]        vp_width;
  logic [13:0]        vp_height;
  out_item_t          pending_pixels [$];
  int unsigned        fail_count;
  int unsigned        idle_cycles = 0;
  int unsigned        send_idle_pct;
  int unsigned        stall_pct;

  function automatic logic signed [65:0] floor_div_pow2(input logic signed [95:0] v,
                                                        input int unsigned s);
    return 66'(v >>> s);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
    if (v > 96'(SMax)) return SMax;
    if (v < 96'(SMin)) return SMin;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fixed_div(input logic signed [31:0] v,
                                                   input logic signed [31:0] w);
    logic signed [95:0] num;
    logic signed [95:0] q;
    num = 96'(v) <<< Frac;
    q = num / 96'(w);
    return clamp32(q);
  endfunction

  function automatic logic signed [31:0] row_sum(input int r, input logic signed [31:0] px,
                                                 input logic signed [31:0] py,
                                                 input logic signed [31:0] pz);
    logic signed [95:0] acc;
    logic signed [31:0] p [4];
    p[0] = px; p[1] = py; p[2] = pz; p[3] = One;
    acc = '0;
    for (int c = 0; c < 4; c++) begin
      acc += 96'(floor_div_pow2(96'(view_mat[r*4+c]) * 96'(p[c]), Frac));
    end
    return clamp32(acc);
  endfunction

  // Works out the pixel result of one item; loads update the matrix only.
  function automatic void project_point(input in_item_t it);
    logic signed [31:0] x, y, z, w;
    logic signed [95:0] t;
    out_item_t r;
    if (it.op == OpLoad) begin
      view_mat[it.row_index*4+0] = it.coef_a;
      view_mat[it.row_index*4+1] = it.coef_b;
      view_mat[it.row_index*4+2] = it.coef_c;
      view_mat[it.row_index*4+3] = it.coef_d;
      return;
    end
    x = row_sum(0, it.point_x, it.point_y, it.point_z);
    y = row_sum(1, it.point_x, it.point_y, it.point_z);
    z = row_sum(2, it.point_x, it.point_y, it.point_z);
    w = row_sum(3, it.point_x, it.point_y, it.point_z);
    r.w_was_zero = (w == 0);
    if (w != 0) begin
      x = fixed_div(x, w);
      y = fixed_div(y, w);
      z = fixed_div(z, w);
      w = fixed_div(w, w);
    end
    t = (96'(x) + 96'(One)) * 96'(signed'({1'b0, vp_width}));
    r.screen_x = clamp32(96'(t >>> 1));
    t = (96'(One) - 96'(y)) * 96'(signed'({1'b0, vp_height}));
    r.screen_y = clamp32(96'(t >>> 1));
    r.inside_view = (96'(x) >= -96'(w)) && (x <= w) && (96'(y) >= -96'(w)) && (y <= w)
                    && (z >= 0) && (z <= w);
    pending_pixels.push_back(r);
  endfunction

  // Result checking and the watchdog, both on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > Watchdog) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected transfer on the result side");
          fail_count++;
        end else begin
          out_item_t e;
          e = pending_pixels.pop_front();
          if (out_data_o.screen_x !== e.screen_x) begin
            $error("screen_x expected %0d got %0d", e.screen_x, out_data_o.screen_x);
            fail_count++;
          end
          if (out_data_o.screen_y !== e.screen_y) begin
            $error("screen_y expected %0d got %0d", e.screen_y, out_data_o.screen_y);
            fail_count++;
          end
          if (out_data_o.inside_view !== e.inside_view) begin
            $error("inside_view expected %0b got %0b", e.inside_view, out_data_o.inside_view);
            fail_count++;
          end
          if (out_data_o.w_was_zero !== e.w_was_zero) begin
            $error("w_was_zero expected %0b got %0b", e.w_was_zero, out_data_o.w_was_zero);
            fail_count++;
          end
        end
      end
    end
  end

  // Random stalling on the result side.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Register write through the configuration port while the block is idle.
  task automatic write_reg(input reg_e idx, input logic [13:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * int'(idx)); pwdata <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == RegWidth) vp_width = val;
    else vp_height = val;
  endtask

  // Drives one item and holds it until the transfer; valid drops only while
  // the sender idles or the stream is drained.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    project_point(it);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return SMax;
      2: return SMin;
      default: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  function automatic in_item_t load_row(input logic [1:0] r, input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input logic signed [31:0] c,
                                        input logic signed [31:0] d);
    in_item_t it;
    it = '0;
    it.op = OpLoad; it.row_index = r;
    it.coef_a = a; it.coef_b = b; it.coef_c = c; it.coef_d = d;
    it.point_x = $urandom(); it.point_y = $urandom(); it.point_z = $urandom();
    return it;
  endfunction

  function automatic in_item_t point_item(input logic signed [31:0] px,
                                          input logic signed [31:0] py,
                                          input logic signed [31:0] pz);
    in_item_t it;
    it = in_item_t'(InW'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom()}));
    it.op = OpTransform;
    it.point_x = px; it.point_y = py; it.point_z = pz;
    return it;
  endfunction

  // Directed table: identity and extreme matrices, then transforms.
  in_item_t    plan [$];

  initial begin
    out_item_t e;
    fail_count = 0; send_idle_pct = 0; stall_pct = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    vp_width = WidthReset; vp_height = HeightReset;
    for (int i = 0; i < 16; i++) view_mat[i] = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Identity matrix: origin maps to the screen centre at reset size.
    plan.push_back(load_row(2'd0, One, 0, 0, 0));
    plan.push_back(load_row(2'd1, 0, One, 0, 0));
    plan.push_back(load_row(2'd2, 0, 0, One, 0));
    plan.push_back(load_row(2'd3, 0, 0, 0, One));
    plan.push_back(point_item(0, 0, 0));
    e.screen_x = 32'sd960 <<< 16; e.screen_y = 32'sd540 <<< 16;
    e.inside_view = 1'b1; e.w_was_zero = 1'b0;
    plan.push_back(point_item(One, -One, One));
    plan.push_back(point_item(SMax, SMin, SMax));
    plan.push_back(point_item(SMin, SMax, SMin));
    plan.push_back(point_item(-One, One, 0));
    // Zero w: bottom row cleared.
    plan.push_back(load_row(2'd3, 0, 0, 0, 0));
    plan.push_back(point_item(One, One, One));
    plan.push_back(point_item(SMax, SMax, SMin));
    // Extreme coefficients everywhere, saturating sums.
    plan.push_back(load_row(2'd0, SMax, SMin, SMax, SMin));
    plan.push_back(load_row(2'd1, SMin, SMax, SMin, SMax));
    plan.push_back(load_row(2'd2, SMax, SMax, SMax, SMax));
    plan.push_back(load_row(2'd3, SMin, SMin, SMin, SMin));
    plan.push_back(point_item(SMax, SMax, SMax));
    plan.push_back(point_item(SMin, SMin, SMin));
    plan.push_back(point_item(-1, -1, -1));
    // Perspective row: w follows z.
    plan.push_back(load_row(2'd3, 0, 0, One, 0));
    plan.push_back(point_item(One, One, 2 * One));
    plan.push_back(point_item(0, 0, -One));
    foreach (plan[i]) begin
      send_item(plan[i]);
      // The origin row's result is known outright; compare the prediction too.
      if (i == 4 && pending_pixels[$] !== e) begin
        $error("origin prediction expected %h got %h", e, pending_pixels[$]);
        fail_count++;
      end
    end
    wait_drain();

    // Random phases with several viewport settings, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(RegWidth, 14'd1);    write_reg(RegHeight, 14'd8192); end
        1: begin write_reg(RegWidth, 14'd8192); write_reg(RegHeight, 14'd1);    end
        2: begin write_reg(RegWidth, 14'h3fff); write_reg(RegHeight, 14'd0);    end
        3: begin write_reg(RegWidth, 14'd0);    write_reg(RegHeight, 14'h3fff); end
        default: begin
          write_reg(RegWidth, 14'($urandom_range(1, 8192)));
          write_reg(RegHeight, 14'($urandom_range(1, 8192)));
        end
      endcase
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 69 : 0;
      stall_pct = (ph % 4 == 2) ? 69 : 0;
      if (ph % 4 == 3) begin send_idle_pct = 7; stall_pct = 7; end
      // A fresh random matrix, then points with occasional reloads.
      for (int r = 0; r < 4; r++) begin
        send_item(load_row(2'(r), rand_coord(), rand_coord(), rand_coord(), rand_coord()));
      end
      for (int n = 0; n < 70; n++) begin
        if ($urandom_range(9) == 0) begin
          send_item(load_row(2'($urandom_range(3)), rand_coord(), rand_coord(),
                             rand_coord(), $urandom_range(1) ? 32'sd0 : rand_coord()));
        end else begin
          send_item(point_item(rand_coord(), rand_coord(), rand_coord()));
        end
        if (n == 35 && ph == 2) wait_drain();
      end
      wait_drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
